// ----- src/hxfr_pkg.sv -----
// Shared types and constants for the header/XOR frame receiver.
package hxfr_pkg;

    localparam int BYTE_W        = 8;
    localparam int PAYLOAD_BYTES = 4;
    localparam int WORD_W        = 32;
    localparam int CNT_W         = 3;
    localparam int CFG_IDX_W     = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_SECOND = 2'd2;

    localparam logic [BYTE_W-1:0] TIMEOUT_RESET    = 8'd15;
    localparam logic [BYTE_W-1:0] HDR_FIRST_RESET  = 8'h55;
    localparam logic [BYTE_W-1:0] HDR_SECOND_RESET = 8'hAA;

    // Item opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] timeout_ticks;
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] payload_word;
        logic              checksum_good;
    } result_t;

endpackage

// ----- src/hxfr_cfg_regs.sv -----
// Configuration register bank for the frame receiver.
module hxfr_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [hxfr_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [hxfr_pkg::BYTE_W-1:0]     wr_data,
    output hxfr_pkg::cfg_t                  cfg
);
    import hxfr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
            cfg_reg.header_first  <= HDR_FIRST_RESET;
            cfg_reg.header_second <= HDR_SECOND_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_TIMEOUT:    cfg_reg.timeout_ticks <= wr_data;
                REG_HDR_FIRST:  cfg_reg.header_first  <= wr_data;
                REG_HDR_SECOND: cfg_reg.header_second <= wr_data;
                // indexes past the list are dropped
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/hxfr_parser.sv -----
// Frame parser: phase, payload packing, running XOR and idle timeout.
module hxfr_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_accept,
    input  logic                         opcode,
    input  logic [hxfr_pkg::BYTE_W-1:0]  rx_byte,
    input  hxfr_pkg::cfg_t               cfg,
    output logic                         res_valid,
    output hxfr_pkg::result_t            res
);
    import hxfr_pkg::*;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_HDR2 = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_CHK  = 2'd3;
    localparam logic [BYTE_W-1:0] TICK_MAX = {BYTE_W{1'b1}};

    logic [1:0]        phase_reg,   phase_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [BYTE_W-1:0] xor_reg,     xor_next;
    logic [WORD_W-1:0] payload_reg, payload_next;
    logic [BYTE_W-1:0] idle_reg,    idle_next;
    logic [CNT_W:0]    count_inc;
    logic [WORD_W-1:0] byte_shifted;

    assign count_inc    = {1'b0, count_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign byte_shifted = {{(WORD_W-BYTE_W){1'b0}}, rx_byte} << {count_reg[1:0], 3'b000};

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        xor_next     = xor_reg;
        payload_next = payload_reg;
        idle_next    = idle_reg;
        res_valid    = 1'b0;
        res.payload_word  = payload_reg;
        res.checksum_good = (rx_byte == xor_reg);

        if (opcode == OP_TICK)
        begin
            if (idle_reg != TICK_MAX)
                idle_next = idle_reg + 8'd1;
            if (phase_reg != PH_HUNT && idle_next > cfg.timeout_ticks)
            begin
                phase_next = PH_HUNT;
                count_next = '0;
            end
        end
        else
        begin
            idle_next = '0;
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == cfg.header_first)
                        phase_next = PH_HDR2;
                end
                PH_HDR2:
                begin
                    if (rx_byte == cfg.header_second)
                    begin
                        phase_next   = PH_DATA;
                        count_next   = '0;
                        xor_next     = '0;
                        payload_next = '0;
                    end
                    else
                        phase_next = PH_HUNT;
                end
                PH_DATA:
                begin
                    // only the first four bytes land in the word
                    if (!count_reg[CNT_W-1])
                        payload_next = payload_reg | byte_shifted;
                    xor_next = xor_reg ^ rx_byte;
                    if (count_inc >= (CNT_W+1)'(PAYLOAD_BYTES))
                    begin
                        phase_next = PH_CHK;
                        count_next = '0;
                    end
                    else
                        count_next = count_inc[CNT_W-1:0];
                end
                PH_CHK:
                begin
                    res_valid  = 1'b1;
                    phase_next = PH_HUNT;
                    count_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            count_reg   <= '0;
            xor_reg     <= '0;
            payload_reg <= '0;
            idle_reg    <= '0;
        end
        else if (item_accept)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            xor_reg     <= xor_next;
            payload_reg <= payload_next;
            idle_reg    <= idle_next;
        end
    end

endmodule

// ----- src/hxfr_out_buf.sv -----
// Two-entry result buffer: output register with a skid stage behind it.
module hxfr_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hxfr_pkg::result_t  push_data,
    output logic               space,
    output logic               out_valid,
    input  logic               out_ready,
    output hxfr_pkg::result_t  out_data
);
    import hxfr_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;

    assign pop   = main_valid_reg && out_ready;
    assign space = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
        else if (pop)
            main_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_reg <= skid_reg;
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
                skid_reg <= push_data;
            else
                main_reg <= push_data;
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

// ----- src/header_xor_frame_receiver.sv -----
// Top level of the header/XOR frame receiver.
//
// Deframes a serial byte stream. A frame is a first header byte, a second
// header byte, four payload bytes and one checksum byte equal to the XOR
// of the payload. Each input item is either a received byte (opcode 0) or
// a one-millisecond tick (opcode 1). The checksum byte of a frame yields
// one result item: the payload packed little-endian (first byte in bits
// 7:0) and a flag that is high when the checksum matches; a bad checksum
// still yields its item. A wrong second header byte sends the parser back
// to hunting. Ticks count idle time since the last byte (saturating at
// 255); once that count exceeds timeout_ticks mid-frame, the partial frame
// is dropped. Throughput is one item per clock: the parser updates its
// state in the cycle of acceptance and places any result in a two-entry
// output buffer, so in_ready stays high while a single result waits and
// drops only when both buffer entries are full. Results are registered in
// the output register, or in the skid entry behind it. Configuration
// (index 0 timeout_ticks, 1 header_first, 2 header_second; other indexes
// are ignored) is always ready and is to be written while the block idles.
module header_xor_frame_receiver (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            opcode,
    input  logic [hxfr_pkg::BYTE_W-1:0]     rx_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [hxfr_pkg::WORD_W-1:0]     payload_word,
    output logic                            checksum_good,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hxfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hxfr_pkg::BYTE_W-1:0]     cfg_data
);
    import hxfr_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t out_data;
    logic    res_valid;
    logic    item_accept;
    logic    buf_space;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // take an item whenever the skid entry is free
    assign in_ready    = buf_space;
    assign item_accept = in_valid && in_ready;

    hxfr_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    hxfr_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_accept (item_accept),
        .opcode      (opcode),
        .rx_byte     (rx_byte),
        .cfg         (cfg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // push only results of items actually accepted
    hxfr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (item_accept && res_valid),
        .push_data (res),
        .space     (buf_space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign payload_word  = out_data.payload_word;
    assign checksum_good = out_data.checksum_good;

endmodule

// ----- tb/frame_result_checker.sv -----
// Channel monitor for the frame receiver: predicts each frame result and compares it.
module frame_result_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            opcode,
    input  logic [hxfr_pkg::BYTE_W-1:0]     rx_byte,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [hxfr_pkg::WORD_W-1:0]     payload_word,
    input  logic                            checksum_good,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [hxfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hxfr_pkg::BYTE_W-1:0]     cfg_data,
    output int                              mismatch_total,
    output int                              frames_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import hxfr_pkg::*;

    typedef enum logic [1:0] {
        SEEK_FIRST,
        SEEK_SECOND,
        IN_PAYLOAD,
        AWAIT_CHECKSUM
    } parse_state_e;

    logic [BYTE_W-1:0] timeout_reg;
    logic [BYTE_W-1:0] first_reg;
    logic [BYTE_W-1:0] second_reg;

    parse_state_e      state;
    logic [CNT_W-1:0]  byte_idx;
    logic [BYTE_W-1:0] xor_acc;
    logic [WORD_W-1:0] word_acc;
    logic [BYTE_W-1:0] idle_count;

    result_t expected_frames[$];
    int      mismatches;

    // Advance the parser by one item; queue a result on a checksum byte.
    function void absorb_item(input logic op, input logic [BYTE_W-1:0] b);
        result_t frame;
        if (op == OP_TICK) begin
            if (idle_count != {BYTE_W{1'b1}})
                idle_count = idle_count + 1'b1;
            if (state != SEEK_FIRST && idle_count > timeout_reg) begin
                state    = SEEK_FIRST;
                byte_idx = '0;
            end
        end
        else begin
            idle_count = '0;
            case (state)
                SEEK_FIRST: begin
                    if (b == first_reg)
                        state = SEEK_SECOND;
                end
                SEEK_SECOND: begin
                    if (b == second_reg) begin
                        state    = IN_PAYLOAD;
                        byte_idx = '0;
                        xor_acc  = '0;
                        word_acc = '0;
                    end
                    else begin
                        state = SEEK_FIRST;
                    end
                end
                IN_PAYLOAD: begin
                    if (int'(byte_idx) < WORD_W / BYTE_W)
                        word_acc = word_acc | (WORD_W'(b) << (BYTE_W * int'(byte_idx)));
                    xor_acc = xor_acc ^ b;
                    if (int'(byte_idx) + 1 >= PAYLOAD_BYTES) begin
                        state    = AWAIT_CHECKSUM;
                        byte_idx = '0;
                    end
                    else begin
                        byte_idx = byte_idx + 1'b1;
                    end
                end
                default: begin
                    frame.payload_word  = word_acc;
                    frame.checksum_good = (b == xor_acc);
                    expected_frames.push_back(frame);
                    state    = SEEK_FIRST;
                    byte_idx = '0;
                end
            endcase
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin : monitor
        result_t want;
        if (!rst_n) begin
            timeout_reg = TIMEOUT_RESET;
            first_reg   = HDR_FIRST_RESET;
            second_reg  = HDR_SECOND_RESET;
            state       = SEEK_FIRST;
            byte_idx    = '0;
            xor_acc     = '0;
            word_acc    = '0;
            idle_count  = '0;
            mismatches  = 0;
            expected_frames.delete();
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TIMEOUT:    timeout_reg = cfg_data;
                    REG_HDR_FIRST:  first_reg   = cfg_data;
                    REG_HDR_SECOND: second_reg  = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                absorb_item(opcode, rx_byte);
            if (out_valid && out_ready) begin
                if (expected_frames.size() == 0) begin
                    $error("unexpected result: payload_word %h checksum_good %b",
                           payload_word, checksum_good);
                    mismatches++;
                end
                else begin
                    want = expected_frames.pop_front();
                    if (payload_word !== want.payload_word) begin
                        $error("payload_word: expected %h, actual %h",
                               want.payload_word, payload_word);
                        mismatches++;
                    end
                    if (checksum_good !== want.checksum_good) begin
                        $error("checksum_good: expected %b, actual %b",
                               want.checksum_good, checksum_good);
                        mismatches++;
                    end
                end
            end
        end
        mismatch_total     <= mismatches;
        frames_outstanding <= expected_frames.size();
    end

endmodule

// ----- tb/header_xor_frame_receiver_test.sv -----
// Stimulus, flow control and verdict for the header/XOR frame receiver.
module header_xor_frame_receiver_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hxfr_pkg::*;

    // Index with no register behind it; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int STALL_LIMIT   = 5000;  // cycles with no handshake before giving up
    localparam int SETTLE_CYCLES = 4;     // parser settles in the cycle of acceptance
    localparam int PHASE_ITEMS   = 150;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 opcode;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic [WORD_W-1:0]    payload_word;
    logic                 checksum_good;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    int mismatch_total;
    int frames_outstanding;

    // Flow-control knobs and counters for the sender and the receiver.
    int sender_idle_pct;
    int stall_pct;
    int hold_requests;
    int holds_served;
    int items_sent;

    // The stimulus's own view of the header and timeout settings, used to
    // build well-formed frames.
    logic [BYTE_W-1:0] cur_timeout;
    logic [BYTE_W-1:0] cur_first;
    logic [BYTE_W-1:0] cur_second;

    header_xor_frame_receiver u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .payload_word  (payload_word),
        .checksum_good (checksum_good),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    frame_result_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .opcode             (opcode),
        .rx_byte            (rx_byte),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .payload_word       (payload_word),
        .checksum_good      (checksum_good),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mismatch_total     (mismatch_total),
        .frames_outstanding (frames_outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one item, after a random idle gap, and hold it until accepted.
    // Valid is only lowered when a gap is taken, so back-to-back items never
    // see valid dropped and raised in the same step.
    task automatic send_item(input logic op, input logic [BYTE_W-1:0] b);
        if ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop valid and wait until every predicted frame has come out, then
    // let the parser settle before anything touches the registers.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (frames_outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_TIMEOUT:    cur_timeout = data;
            REG_HDR_FIRST:  cur_first   = data;
            REG_HDR_SECOND: cur_second  = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [BYTE_W-1:0] t, input logic [BYTE_W-1:0] f,
                              input logic [BYTE_W-1:0] s);
        write_reg(REG_TIMEOUT, t);
        write_reg(REG_HDR_FIRST, f);
        write_reg(REG_HDR_SECOND, s);
    endtask

    // Send one frame built from the current headers. A burst of tick_count
    // ticks goes in front of byte tick_pos (1 = second header, 6 = checksum).
    task automatic send_frame(input logic [WORD_W-1:0] word, input bit good,
                              input int tick_count, input int tick_pos);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        int i;
        sum = '0;
        for (i = 0; i < 7; i++) begin
            if (i == tick_pos)
                repeat (tick_count) send_item(OP_TICK, BYTE_W'($urandom_range(255)));
            if (i == 0)
                b = cur_first;
            else if (i == 1)
                b = cur_second;
            else if (i < 6) begin
                b   = word[(i - 2) * BYTE_W +: BYTE_W];
                sum = sum ^ b;
            end
            else
                b = good ? sum : sum ^ BYTE_W'($urandom_range(1, 255));
            send_item(OP_BYTE, b);
        end
    endtask

    // Random frame, mostly with a good checksum; now and then stall it with
    // ticks right at the timeout boundary, or one to three other ticks.
    task automatic random_frame();
        int ticks;
        int roll;
        ticks = 0;
        roll  = $urandom_range(99);
        if (roll < 25) begin
            if (cur_timeout <= 40 && roll < 16)
                ticks = int'(cur_timeout) + (roll % 2);
            else
                ticks = $urandom_range(1, 3);
        end
        send_frame($urandom, $urandom_range(9) != 0, ticks, $urandom_range(1, 6));
    endtask

    // Mostly well-formed frames with random content; the rest broken headers,
    // abandoned frames, stray bytes and tick bursts.
    task automatic run_random(input int n);
        int target;
        int roll;
        target = items_sent + n;
        while (items_sent < target) begin
            roll = $urandom_range(99);
            if (roll < 65) begin
                random_frame();
            end
            else if (roll < 75) begin
                // wrong second header, sometimes a repeat of the first
                send_item(OP_BYTE, cur_first);
                send_item(OP_BYTE, $urandom_range(1) ? cur_first
                                                     : BYTE_W'($urandom_range(255)));
            end
            else if (roll < 82) begin
                // frame cut short, then left to time out if the timeout is under 40
                send_item(OP_BYTE, cur_first);
                send_item(OP_BYTE, cur_second);
                repeat ($urandom_range(1, 3)) send_item(OP_BYTE, BYTE_W'($urandom_range(255)));
                if (cur_timeout < 40)
                    repeat (int'(cur_timeout) + 1) send_item(OP_TICK, BYTE_W'($urandom_range(255)));
            end
            else if (roll < 92) begin
                repeat ($urandom_range(1, 4)) send_item(OP_BYTE, BYTE_W'($urandom_range(255)));
            end
            else begin
                repeat ($urandom_range(1, 8)) send_item(OP_TICK, BYTE_W'($urandom_range(255)));
            end
        end
    endtask

    // Receiver: random back-pressure, plus a long hold-off on request that
    // it counts out itself.
    initial begin
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_requests != holds_served) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_served++;
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: give up once no channel has moved an item for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int phase;
        logic [BYTE_W-1:0] hdr;
        in_valid        = 1'b0;
        opcode          = OP_BYTE;
        rx_byte         = '0;
        cfg_valid       = 1'b0;
        cfg_index       = REG_TIMEOUT;
        cfg_data        = '0;
        rst_n           = 1'b0;
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_requests   = 0;
        holds_served    = 0;
        items_sent      = 0;
        cur_timeout     = TIMEOUT_RESET;
        cur_first       = HDR_FIRST_RESET;
        cur_second      = HDR_SECOND_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset settings: all-zero payload with a good
        // checksum, all-ones payload with a bad one, a second header that
        // repeats the first, then a clean frame to show the parser recovered.
        send_frame(32'h0000_0000, 1'b1, 0, 0);
        send_frame(32'hFFFF_FFFF, 1'b0, 0, 0);
        send_item(OP_BYTE, cur_first);
        send_item(OP_BYTE, cur_first);
        send_item(OP_BYTE, cur_second);
        send_frame(32'h0403_0201, 1'b1, 0, 0);
        drain_results();

        // Timeout boundary: ticks equal to the limit keep the frame, one more
        // drops it.
        set_config(8'd1, HDR_FIRST_RESET, HDR_SECOND_RESET);
        send_frame(32'h8000_0001, 1'b1, 1, 3);
        send_frame(32'h1234_5678, 1'b1, 2, 3);
        drain_results();

        // Zero timeout: a single tick mid-frame is already too many.
        set_config(8'd0, HDR_FIRST_RESET, HDR_SECOND_RESET);
        send_frame(32'hA5A5_5A5A, 1'b1, 1, 1);
        send_frame(32'h0102_0408, 1'b1, 0, 0);
        drain_results();

        // Largest timeout: the idle count saturates and never exceeds it.
        set_config(8'd255, HDR_FIRST_RESET, HDR_SECOND_RESET);
        send_frame(32'hDEAD_BEEF, 1'b1, 300, 4);
        drain_results();
        write_reg(REG_UNUSED, BYTE_W'($urandom_range(255)));

        // Random part: one register setting and one flow-control mode per phase.
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_config(TIMEOUT_RESET, HDR_FIRST_RESET, HDR_SECOND_RESET);
                1: set_config(8'd0, 8'h00, 8'hFF);
                2: set_config(8'd255, 8'hFF, 8'h00);
                3: begin
                    // identical headers
                    hdr = BYTE_W'($urandom_range(255));
                    set_config(BYTE_W'($urandom_range(0, 40)), hdr, hdr);
                end
                default: set_config(BYTE_W'($urandom_range(0, 30)),
                                    BYTE_W'($urandom_range(255)),
                                    BYTE_W'($urandom_range(255)));
            endcase
            case (phase % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 62; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 62; end
                default: begin sender_idle_pct = 20; stall_pct = 20; end
            endcase
            if (phase == 4) begin
                // Hold the receiver off while frames keep coming, so the
                // output buffer fills and the input stalls.
                hold_requests++;
                repeat (6) send_frame($urandom, 1'b1, 0, 0);
            end
            run_random(PHASE_ITEMS);
            drain_results();
        end

        if (mismatch_total == 0 && frames_outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- header_xor_frame_receiver.f -----
src/hxfr_pkg.sv
src/hxfr_cfg_regs.sv
src/hxfr_parser.sv
src/hxfr_out_buf.sv
src/header_xor_frame_receiver.sv
tb/frame_result_checker.sv
tb/header_xor_frame_receiver_test.sv
